>>> src/oledfb_pkg.sv
// shared types and constants for the oled page frame store refresh block
package oledfb_pkg;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_REFRESH = 1'b1;

   localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

   // position of a byte in the command header
   localparam logic [1:0] CMDI_PAGE_ADDR = 2'd0;
   localparam logic [1:0] CMDI_PAGE      = 2'd1;
   localparam logic [1:0] CMDI_COL_LOW   = 2'd2;
   localparam logic [1:0] CMDI_COL_HIGH  = 2'd3;

   typedef struct packed {
      logic       operation;
      logic [6:0] pixel_column;
      logic [4:0] pixel_line;
      logic       pixel_shade;
      logic [1:0] strip_index;
      logic [1:0] page_index;
   } cmd_type;

endpackage

>>> src/oledfb_if.sv
// request and response channel interfaces
interface oledfb_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [6:0] pixel_column;
   logic [4:0] pixel_line;
   logic       pixel_shade;
   logic [1:0] strip_index;
   logic [1:0] page_index;

   modport source (
      output valid, operation, pixel_column, pixel_line, pixel_shade, strip_index, page_index,
      input  ready
   );
   modport sink (
      input  valid, operation, pixel_column, pixel_line, pixel_shade, strip_index, page_index,
      output ready
   );
endinterface

interface oledfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_data;
   logic       last;

   modport source (
      output valid, out_byte, is_data, last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, is_data, last,
      output ready
   );
endinterface

>>> src/oled_page_framebuffer_refresh.sv
// top level: oled page-mode frame store with strip refresh
// a pixel write does a store read, then a modified write, and gives no beat
// a refresh gives 36 beats, one beat per cycle while the sink is ready, with a pause
// between the command header and the data bytes
// a refresh holds the back end through these steps in order: take, 4 header, 32 reads, drain
// reset clears per-column valid bits at once, so the store reads blank with no clearing pass
module oled_page_framebuffer_refresh #(
   parameter int FRAME_COLUMNS = 128,
   parameter int FRAME_ROWS    = 32,
   parameter int STRIP_WIDTH   = 32
) (
   input  logic         clock,
   input  logic         reset,
   oledfb_req_if.sink   req_bus,
   oledfb_rsp_if.source rsp_bus
);

   logic                q_ready, q_push, q_pop, q_valid;
   oledfb_pkg::cmd_type q_push_cmd, q_head_cmd;

   oledfb_front #(
      .FRAME_COLUMNS (FRAME_COLUMNS),
      .FRAME_ROWS    (FRAME_ROWS)
   ) u_front (
      .req_bus    (req_bus),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_push_cmd (q_push_cmd)
   );

   oledfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   oledfb_back #(
      .FRAME_COLUMNS (FRAME_COLUMNS),
      .FRAME_ROWS    (FRAME_ROWS),
      .STRIP_WIDTH   (STRIP_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_head_cmd),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

>>> src/oledfb_front.sv
// front end: accepts request beats, drops off-frame pixel writes, queues the rest
module oledfb_front #(
   parameter int FRAME_COLUMNS = 128,
   parameter int FRAME_ROWS    = 32
) (
   oledfb_req_if.sink           req_bus,
   input  logic                 q_ready,
   output logic                 q_push,
   output oledfb_pkg::cmd_type  q_push_cmd
);

   logic in_frame;

   assign req_bus.ready = q_ready;

   assign in_frame = (32'(req_bus.pixel_column) < FRAME_COLUMNS) &&
                     (32'(req_bus.pixel_line) < FRAME_ROWS);

   assign q_push = req_bus.valid && q_ready &&
                   ((req_bus.operation == oledfb_pkg::OP_REFRESH) || in_frame);

   always_comb begin
      q_push_cmd.operation    = req_bus.operation;
      q_push_cmd.pixel_column = req_bus.pixel_column;
      q_push_cmd.pixel_line   = req_bus.pixel_line;
      q_push_cmd.pixel_shade  = req_bus.pixel_shade;
      q_push_cmd.strip_index  = req_bus.strip_index;
      q_push_cmd.page_index   = req_bus.page_index;
   end

endmodule

>>> src/oledfb_queue.sv
// two-entry queue between front and back end
module oledfb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  oledfb_pkg::cmd_type  push_cmd,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 head_valid,
   output oledfb_pkg::cmd_type  head_cmd
);

   oledfb_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/oledfb_back.sv
// back end: frame store, pixel read-modify-write and strip page byte sequencer
module oledfb_back #(
   parameter int FRAME_COLUMNS = 128,
   parameter int FRAME_ROWS    = 32,
   parameter int STRIP_WIDTH   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  oledfb_pkg::cmd_type  q_cmd,
   output logic                 q_pop,
   oledfb_rsp_if.source         rsp_bus
);

   localparam int CW = $clog2(FRAME_COLUMNS);
   localparam int XW = $clog2(4 * STRIP_WIDTH);
   localparam int JW = $clog2(STRIP_WIDTH);
   localparam int RX = FRAME_ROWS + 32;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CMD    = 2'd1;
   localparam logic [1:0] ST_DATA   = 2'd2;
   localparam logic [1:0] ST_WR_MOD = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [JW-1:0]         j_ff, j_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [1:0]            page_ff, page_in;
   logic [CW-1:0]         wcol_ff;
   logic [4:0]            wrow_ff;
   logic                  wval_ff;
   logic                  pend_ff, pend_in;
   logic                  pend_ok_ff;
   logic                  pend_last_ff;
   logic [FRAME_ROWS-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic [FRAME_COLUMNS-1:0] valid_ff;
   logic [FRAME_ROWS-1:0] store_mem [FRAME_COLUMNS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff;
   logic                  rsp_is_data_ff;
   logic                  rsp_last_ff;

   logic                  out_free, move, issue, cmd_emit, rd_en;
   logic [XW-1:0]         data_col;
   logic [CW+XW-1:0]      data_col_ext;
   logic [CW+6:0]         q_col_ext;
   logic                  col_ok;
   logic [CW-1:0]         rd_addr;
   logic [FRAME_ROWS-1:0] word, wr_mask, new_word;
   logic [RX-1:0]         word_x;
   logic [7:0]            page_bits, row_mask, data_byte, cmd_byte;
   logic [XW+7:0]         x_ext;

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign move         = pend_ff && out_free;
   assign issue        = (state_ff == ST_DATA) && (!pend_ff || move);
   assign cmd_emit     = (state_ff == ST_CMD) && out_free;
   assign q_pop        = q_valid && (state_ff == ST_IDLE) && !pend_ff;
   assign rd_en        = issue || (q_pop && (q_cmd.operation == oledfb_pkg::OP_WRITE));

   assign data_col     = x_ff + XW'(j_ff);
   assign data_col_ext = (CW + XW)'(data_col);
   assign q_col_ext    = (CW + 7)'(q_cmd.pixel_column);
   assign col_ok       = (32'(data_col) < FRAME_COLUMNS);
   assign rd_addr      = (state_ff == ST_DATA) ? data_col_ext[CW-1:0] : q_col_ext[CW-1:0];

   // entries never written read as blank
   assign word     = rd_valid_ff ? rd_data_ff : {FRAME_ROWS{1'b1}};
   assign wr_mask  = FRAME_ROWS'(1) << wrow_ff;
   assign new_word = wval_ff ? (word | wr_mask) : (word & ~wr_mask);

   assign word_x    = RX'(word);
   assign page_bits = 8'(word_x >> {page_ff, 3'b000});
   assign data_byte = pend_ok_ff ? (~page_bits & row_mask) : 8'h00;
   assign x_ext     = (XW + 8)'(x_ff);

   always_comb begin
      for (int r = 0; r < 8; r++) begin
         row_mask[r] = (32'({page_ff, 3'(r)}) < FRAME_ROWS);
      end
   end

   always_comb begin
      case (cnt_ff)
         oledfb_pkg::CMDI_PAGE_ADDR: cmd_byte = oledfb_pkg::CMD_PAGE_ADDR;
         oledfb_pkg::CMDI_PAGE:      cmd_byte = 8'(page_ff);
         oledfb_pkg::CMDI_COL_LOW:   cmd_byte = x_ext[7:0] & oledfb_pkg::NIBBLE_MASK;
         oledfb_pkg::CMDI_COL_HIGH:  cmd_byte = oledfb_pkg::CMD_COL_HIGH |
                                                ((x_ext[7:0] >> 4) & oledfb_pkg::NIBBLE_MASK);
         default:                    cmd_byte = oledfb_pkg::CMD_PAGE_ADDR;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      x_in     = x_ff;
      page_in  = page_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_cmd.operation == oledfb_pkg::OP_REFRESH) begin
                  state_in = ST_CMD;
                  cnt_in   = oledfb_pkg::CMDI_PAGE_ADDR;
                  page_in  = q_cmd.page_index;
                  x_in     = XW'(q_cmd.strip_index * STRIP_WIDTH);
               end else begin
                  state_in = ST_WR_MOD;
               end
            end
         end
         ST_CMD: begin
            if (cmd_emit) begin
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == oledfb_pkg::CMDI_COL_HIGH) begin
                  state_in = ST_DATA;
                  j_in     = '0;
               end
            end
         end
         ST_DATA: begin
            if (issue) begin
               j_in = j_ff + JW'(1);
               if (j_ff == JW'(STRIP_WIDTH - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WR_MOD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pend_in      = issue ? 1'b1 : (move ? 1'b0 : pend_ff);
   assign rsp_valid_in = (cmd_emit || move) ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= oledfb_pkg::CMDI_PAGE_ADDR;
         j_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_WR_MOD) begin
            valid_ff[wcol_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      page_ff <= page_in;
      if (q_pop) begin
         wcol_ff <= q_col_ext[CW-1:0];
         wrow_ff <= q_cmd.pixel_line;
         wval_ff <= q_cmd.pixel_shade;
      end
      if (issue) begin
         pend_ok_ff   <= col_ok;
         pend_last_ff <= (j_ff == JW'(STRIP_WIDTH - 1));
      end
      if (cmd_emit) begin
         rsp_byte_ff    <= cmd_byte;
         rsp_is_data_ff <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else if (move) begin
         rsp_byte_ff    <= data_byte;
         rsp_is_data_ff <= 1'b1;
         rsp_last_ff    <= pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WR_MOD) begin
         store_mem[wcol_ff] <= new_word;
      end
      if (rd_en) begin
         rd_data_ff  <= store_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.is_data  = rsp_is_data_ff;
   assign rsp_bus.last     = rsp_last_ff;

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock) !reset && $past(reset) |-> state_ff == ST_IDLE)
      else $error("sequencer not idle after reset");
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_is_data_ff)
      else $error("last flag on a command beat");
   a_rmw_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR_MOD |-> !pend_ff)
      else $error("pixel write overlaps a pending data read");
   a_refresh_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_cmd.operation == oledfb_pkg::OP_REFRESH |=> state_ff == ST_CMD)
      else $error("refresh did not enter command phase");
`endif

endmodule
